### sv/mcx_pkg.sv
// shared types and constants for the monochrome color expansion blit
// no dependencies; imported by every module of the block
package mcx_pkg;

    localparam int WORD_BITS  = 16;
    localparam int SIZE_BITS  = 13;
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;
    localparam int TDATA_BITS = 64;

    localparam logic [3:0] TOP_BIT = 4'd15;

    typedef enum logic [1:0] {
        MODE_REPLACE     = 2'd0,
        MODE_TRANSPARENT = 2'd1,
        MODE_XOR         = 2'd2,
        MODE_REVERSE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_KEEP   = 2'd1,
        ACT_INVERT = 2'd2
    } action_t;

    localparam logic [31:0] REG_DRAW_MODE  = 32'd0;
    localparam logic [31:0] REG_FOREGROUND = 32'd1;
    localparam logic [31:0] REG_BACKGROUND = 32'd2;
    localparam logic [31:0] REG_START_BIT  = 32'd3;
    localparam logic [31:0] REG_WIDTH      = 32'd4;
    localparam logic [31:0] REG_HEIGHT     = 32'd5;

    // settings seen by the expander
    typedef struct packed {
        mode_t                  mode;
        logic [COLOR_BITS-1:0]  fg;
        logic [COLOR_BITS-1:0]  bg;
        logic [3:0]             offset;
        logic [SIZE_BITS-1:0]   eff_width;
        logic [SIZE_BITS-1:0]   eff_height;
        logic                   restart;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  column;
        action_t                action;
        logic [COLOR_BITS-1:0]  value;
        logic                   last_of_word;
        logic                   end_of_area;
    } pixel_t;

endpackage

### sv/mcx_cfg_regs.sv
// configuration register file with size clamping and restart pulse
// depends on mcx_pkg
module mcx_cfg_regs
    import mcx_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    localparam logic [COLOR_BITS-1:0] COLOR_MASK =
        COLOR_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

    mode_t                 mode_reg;
    logic [COLOR_BITS-1:0] fg_reg;
    logic [COLOR_BITS-1:0] bg_reg;
    logic [3:0]            offset_reg;
    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    logic                  restart_reg;
    logic                  wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_REPLACE;
            fg_reg      <= '0;
            bg_reg      <= '0;
            offset_reg  <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            // only a write to an existing register restarts the blit
            restart_reg <= wr && (cfg_index <= REG_HEIGHT);
            if (wr)
            begin
                case (cfg_index)
                    REG_DRAW_MODE:  mode_reg   <= mode_t'(cfg_data[1:0]);
                    REG_FOREGROUND: fg_reg     <= cfg_data;
                    REG_BACKGROUND: bg_reg     <= cfg_data;
                    REG_START_BIT:  offset_reg <= cfg_data[3:0];
                    REG_WIDTH:      width_reg  <= cfg_data[SIZE_BITS-1:0];
                    REG_HEIGHT:     height_reg <= cfg_data[SIZE_BITS-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.mode       = mode_reg;
        cfg.fg         = fg_reg & COLOR_MASK;
        cfg.bg         = bg_reg & COLOR_MASK;
        cfg.offset     = offset_reg;
        cfg.eff_width  = (32'(width_reg) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH) : width_reg;
        cfg.eff_height = (32'(height_reg) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT) : height_reg;
        cfg.restart    = restart_reg;
    end

endmodule

### sv/mcx_expand.sv
// word holding register and scan state: one pixel per cycle unless stalled
// depends on mcx_pkg; fed by mcx_cfg_regs, drains into mcx_out_reg
module mcx_expand
    import mcx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,
    input  logic                 load_ok,
    output logic                 pix_valid,
    output pixel_t               pix
);

    logic [WORD_BITS-1:0]  word_reg;
    logic                  held_reg, held_next;
    logic [3:0]            bit_reg, bit_next;
    logic [SIZE_BITS-1:0]  left_reg, left_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  done_reg, done_next;

    logic                  step;
    logic                  consume;
    logic                  emit;
    logic                  is_set;
    logic [SIZE_BITS-1:0]  left_dec;
    logic                  row_end;
    logic                  last_row;
    logic [3:0]            first_bit;

    assign first_bit = TOP_BIT - cfg.offset;
    assign is_set    = word_reg[bit_reg];
    assign left_dec  = left_reg - SIZE_BITS'(1);
    assign row_end   = (left_dec == '0);
    assign last_row  = (({1'b0, row_reg} + SIZE_BITS'(1)) >= cfg.eff_height);
    assign step      = held_reg && load_ok;
    assign s_tready  = !held_reg || (step && consume);

    always_comb
    begin
        bit_next  = bit_reg;
        left_next = left_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        consume   = 1'b1;
        emit      = 1'b0;

        pix.row          = row_reg;
        pix.column       = col_reg;
        pix.action       = ACT_KEEP;
        pix.value        = '0;
        pix.last_of_word = row_end || (bit_reg == '0);
        pix.end_of_area  = row_end && last_row;

        case (cfg.mode)
            MODE_REPLACE:
            begin
                pix.action = ACT_WRITE;
                pix.value  = is_set ? cfg.fg : cfg.bg;
            end
            MODE_TRANSPARENT:
            begin
                if (is_set)
                begin
                    pix.action = ACT_WRITE;
                    pix.value  = cfg.fg;
                end
            end
            MODE_XOR:
            begin
                if (is_set)
                    pix.action = ACT_INVERT;
            end
            default:
            begin
                if (!is_set)
                begin
                    pix.action = ACT_WRITE;
                    pix.value  = cfg.fg;
                end
            end
        endcase

        if (cfg.restart)
        begin
            bit_next  = first_bit;
            left_next = cfg.eff_width;
            col_next  = '0;
            row_next  = '0;
            done_next = (cfg.eff_height == '0);
        end
        else if (step && !done_reg)
        begin
            // a row with nothing left takes a surplus word and moves on
            if (left_reg == '0)
            begin
                if (last_row)
                    done_next = 1'b1;
                else
                begin
                    row_next  = row_reg + COORD_BITS'(1);
                    bit_next  = first_bit;
                    left_next = cfg.eff_width;
                    col_next  = '0;
                end
            end
            else
            begin
                emit      = 1'b1;
                left_next = left_dec;
                col_next  = col_reg + COORD_BITS'(1);
                if (row_end)
                begin
                    if (bit_reg == '0)
                        bit_next = TOP_BIT;
                    else if (last_row)
                        done_next = 1'b1;
                    else
                    begin
                        row_next  = row_reg + COORD_BITS'(1);
                        bit_next  = first_bit;
                        left_next = cfg.eff_width;
                        col_next  = '0;
                    end
                end
                else if (bit_reg == '0)
                    bit_next = TOP_BIT;
                else
                begin
                    bit_next = bit_reg - 4'd1;
                    consume  = 1'b0;
                end
            end
        end

        held_next = held_reg;
        if (step && consume)
            held_next = 1'b0;
        if (s_tvalid && s_tready)
            held_next = 1'b1;
    end

    assign pix_valid = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            bit_reg  <= TOP_BIT;
            left_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            held_reg <= held_next;
            bit_reg  <= bit_next;
            left_reg <= left_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            word_reg <= s_tdata;
    end

endmodule

### sv/mcx_out_reg.sv
// result register between the expander and the master stream
// depends on mcx_pkg
module mcx_out_reg
    import mcx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    input  pixel_t                pix,
    output logic                  load_ok,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    pixel_t pix_reg;
    logic   valid_reg;

    assign load_ok = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ok)
            valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && pix_valid)
            pix_reg <= pix;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, pix_reg.value, pix_reg.action, pix_reg.column, pix_reg.row};
    assign m_tlast  = pix_reg.last_of_word;
    assign m_tuser  = pix_reg.end_of_area;

endmodule

### sv/mono_color_expand_blit.sv
// top level of the monochrome color expansion blit
// depends on mcx_pkg, mcx_cfg_regs, mcx_expand, mcx_out_reg
//
// usage:
//   s_* carries 16-bit source words, bit 15 the leftmost pixel. each word
//   expands into up to sixteen pixel beats on m_*, one per cycle unless stalled.
//   cfg_* writes a register (0 mode, 1 fg, 2 bg, 3 start bit, 4 width,
//   5 height); each such write restarts the blit at row 0. write only while idle.
//   a word accepted into the holding register is expanded pixel by pixel and
//   each pixel passes through the result register onto m_*. the word stays
//   held until it has yielded its pixels (16 for an inner word, fewer at row
//   edges, none for a surplus word), paced by the single pixel-per-cycle expander.
//   reset: configuration registers zero, area empty, no beats pending.
//   stall: while m_tready is low a full result register holds its beat and the
//   expander waits; s_tready drops once a word is held and not yet finished.
//   the next word is taken in the cycle its predecessor's last pixel is registered.
module mono_color_expand_blit
    import mcx_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_BITS-1:0]  s_tdata,   // source_word[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // pixel_row[11:0], pixel_column[23:12],
                                             // pixel_action[25:24], pixel_value[57:26]
    output logic                  m_tlast,   // last_of_word
    output logic                  m_tuser    // end_of_area
);

    cfg_t   cfg;
    pixel_t pix;
    logic   pix_valid;
    logic   load_ok;

    mcx_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcx_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .load_ok   (load_ok),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    mcx_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix       (pix),
        .load_ok   (load_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // the final pixel of the area always closes its word
    a_area_end_closes_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of area without last of word");

    a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:24] == ACT_WRITE || m_tdata[25:24] == ACT_KEEP ||
                      m_tdata[25:24] == ACT_INVERT))
        else $error("illegal pixel action");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:24] != ACT_WRITE) |-> (m_tdata[57:26] == '0))
        else $error("nonzero value on keep or invert");

    // a pixel is only produced when the result register can take it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> load_ok)
        else $error("pixel produced into a full result register");

endmodule

### verif/tb_mono_color_expand_blit.sv
`timescale 1ns / 100ps
// self-checking testbench for mono_color_expand_blit: register writes, source words, pixel beats
// depends on mcx_pkg and mono_color_expand_blit; expected pixels come from an in-bench expander
module tb_mono_color_expand_blit;
    import mcx_pkg::*;

    localparam int MAX_W        = 4096;
    localparam int MAX_H        = 4096;
    localparam int NUM_REGS     = 6;
    localparam int ITEMS        = 380;
    localparam int PHASE_WORDS  = 24;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_WAIT     = 20000;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int N_DIRECTED   = 41;

    // no register lives at this index; a write must change nothing
    localparam logic [31:0] REG_UNUSED = 32'd6;
    localparam logic signed [5:0] NOT_TYPED = -6'sd1;

    typedef enum logic {
        ROW_WRITE_REG,
        ROW_SEND_WORD
    } row_kind_t;

    // n_pixels and the first pixel's action and value are typed in where obvious
    typedef struct packed {
        row_kind_t          kind;
        logic [31:0]        index;
        logic [31:0]        data;
        logic signed [5:0]  n_pixels;
        action_t            first_action;
        logic [31:0]        first_value;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_index = '0;
    logic [31:0]           cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [WORD_BITS-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // expander state and its copy of the registers
    mode_t                 blit_mode;
    logic [COLOR_BITS-1:0] fg_color;
    logic [COLOR_BITS-1:0] bg_color;
    logic [3:0]            start_offset;
    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    logic [3:0]            bit_index;
    logic [SIZE_BITS-1:0]  pixels_left;
    logic [COORD_BITS-1:0] column_now;
    logic [COORD_BITS-1:0] row_now;
    logic                  area_finished;

    pixel_t expected_pixels[$];

    int mismatch_count = 0;
    int beats_checked  = 0;
    int words_sent     = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        // empty area straight out of reset
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_FOREGROUND, 32'hffff_ffff, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_BACKGROUND, 32'h0000_0000, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_WIDTH, 32'd16, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_HEIGHT, 32'd2, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_START_BIT, 32'd0, NOT_TYPED, ACT_WRITE, 32'h0},
        // rows end on bit 0, so each row takes a trailing word that yields nothing
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd16, ACT_WRITE, 32'hffff_ffff},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_0000, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_0000, 6'sd16, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_1234, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_DRAW_MODE, 32'(MODE_TRANSPARENT), NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_START_BIT, 32'd15, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_WIDTH, 32'd3, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_HEIGHT, 32'd1, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_0001, 6'sd1, ACT_WRITE, 32'hffff_ffff},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_4000, 6'sd2, ACT_KEEP, 32'h0},
        '{ROW_WRITE_REG, REG_DRAW_MODE, 32'(MODE_XOR), NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_START_BIT, 32'd7, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_WIDTH, 32'd9, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_01ff, 6'sd9, ACT_INVERT, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        // oversized area saturates to the maximum
        '{ROW_WRITE_REG, REG_DRAW_MODE, 32'(MODE_REVERSE), NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_START_BIT, 32'd0, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_HEIGHT, 32'h1fff, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_WIDTH, 32'h1fff, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_0000, 6'sd16, ACT_WRITE, 32'hffff_ffff},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_aaaa, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_5555, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_DRAW_MODE, 32'(MODE_REPLACE), NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_BACKGROUND, 32'hffff_ffff, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_FOREGROUND, 32'h0000_0000, NOT_TYPED, ACT_WRITE, 32'h0},
        // zero width: each word just steps to the next row until the area ends
        '{ROW_WRITE_REG, REG_WIDTH, 32'd0, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_HEIGHT, 32'd3, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_UNUSED, 32'h1234_5678, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_ffff, 6'sd0, ACT_WRITE, 32'h0},
        '{ROW_WRITE_REG, REG_WIDTH, 32'd20, NOT_TYPED, ACT_WRITE, 32'h0},
        '{ROW_SEND_WORD, 32'd0, 32'h0000_0f0f, NOT_TYPED, ACT_WRITE, 32'h0}
    };

    mono_color_expand_blit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [SIZE_BITS-1:0] clipped_width();
        return (int'(width_reg) > MAX_W) ? SIZE_BITS'(MAX_W) : width_reg;
    endfunction

    function automatic logic [SIZE_BITS-1:0] clipped_height();
        return (int'(height_reg) > MAX_H) ? SIZE_BITS'(MAX_H) : height_reg;
    endfunction

    function automatic void start_row();
        bit_index   = TOP_BIT - start_offset;
        pixels_left = clipped_width();
        column_now  = '0;
    endfunction

    function automatic void restart_blit();
        start_row();
        row_now       = '0;
        area_finished = (clipped_height() == 0);
    endfunction

    function automatic void advance_row();
        if (int'(row_now) + 1 >= int'(clipped_height()))
        begin
            area_finished = 1'b1;
            return;
        end
        row_now = row_now + 1'b1;
        start_row();
    endfunction

    function automatic void apply_register(input logic [31:0] idx, input logic [31:0] data);
        case (idx)
            REG_DRAW_MODE:  blit_mode    = mode_t'(data[1:0]);
            REG_FOREGROUND: fg_color     = data;
            REG_BACKGROUND: bg_color     = data;
            REG_START_BIT:  start_offset = data[3:0];
            REG_WIDTH:      width_reg    = data[SIZE_BITS-1:0];
            REG_HEIGHT:     height_reg   = data[SIZE_BITS-1:0];
            default:        return;
        endcase
        restart_blit();
    endfunction

    // queues the pixels one source word yields and returns how many
    function automatic int predict_word(input logic [15:0] word);
        logic [3:0] b;
        logic       is_set;
        logic       row_end;
        logic       word_done;
        pixel_t     px;
        int         n;
        n = 0;
        b = bit_index;
        word_done = 1'b0;
        if (area_finished)
            return 0;
        if (pixels_left == 0)
        begin
            advance_row();
            return 0;
        end
        while (!word_done)
        begin
            is_set          = word[b];
            pixels_left     = pixels_left - 1'b1;
            row_end         = (pixels_left == 0);
            px.row          = row_now;
            px.column       = column_now;
            px.last_of_word = row_end || (b == 4'd0);
            px.end_of_area  = row_end && (int'(row_now) + 1 >= int'(clipped_height()));
            px.action       = ACT_KEEP;
            px.value        = '0;
            case (blit_mode)
                MODE_REPLACE:
                begin
                    px.action = ACT_WRITE;
                    px.value  = is_set ? fg_color : bg_color;
                end
                MODE_TRANSPARENT:
                    if (is_set)
                    begin
                        px.action = ACT_WRITE;
                        px.value  = fg_color;
                    end
                MODE_XOR:
                    if (is_set)
                        px.action = ACT_INVERT;
                default:
                    if (!is_set)
                    begin
                        px.action = ACT_WRITE;
                        px.value  = fg_color;
                    end
            endcase
            expected_pixels.push_back(px);
            n++;
            column_now = column_now + 1'b1;
            if (row_end || b == 4'd0)
            begin
                word_done = 1'b1;
                // a row ending on bit 0 still owes a word that yields nothing
                if (b == 4'd0)
                    bit_index = TOP_BIT;
                else
                    advance_row();
            end
            else
                b = b - 1'b1;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // lets the block go quiet before a register write
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [31:0] idx, input logic [31:0] data);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [15:0] word, output int n_pixels);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        n_pixels = predict_word(word);
        words_sent++;
    endtask

    // sender works in bursts; a gap between bursts drops tvalid
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(0, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver stall pattern: a 16-bit ready mask, replayed and then redrawn
    initial
    begin : ready_pattern
        logic [15:0] pattern;
        int          k;
        forever
        begin
            case ($urandom_range(0, 4))
                0:       pattern = 16'hffff;
                1:       pattern = 16'h0001;
                2:       pattern = 16'h5555;
                default: pattern = 16'($urandom_range(1, 65535));
            endcase
            for (k = 0; k < 64; k++)
            begin
                @(posedge clk);
                m_tready <= pattern[k % 16];
            end
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.row          = m_tdata[11:0];
            got.column       = m_tdata[23:12];
            got.action       = action_t'(m_tdata[25:24]);
            got.value        = m_tdata[57:26];
            got.last_of_word = m_tlast;
            got.end_of_area  = m_tuser;
            beats_checked++;
            if (m_tdata[63:58] != '0)
                report_mismatch("tdata padding", m_tdata[63:58], 0);
            if (expected_pixels.size() == 0)
                report_mismatch("pixel beat with nothing expected", m_tdata, 0);
            else
            begin
                want = expected_pixels.pop_front();
                if (got.row != want.row)
                    report_mismatch("pixel_row", got.row, want.row);
                if (got.column != want.column)
                    report_mismatch("pixel_column", got.column, want.column);
                if (got.action != want.action)
                    report_mismatch("pixel_action", got.action, want.action);
                if (got.value != want.value)
                    report_mismatch("pixel_value", got.value, want.value);
                if (got.last_of_word != want.last_of_word)
                    report_mismatch("last_of_word", got.last_of_word, want.last_of_word);
                if (got.end_of_area != want.end_of_area)
                    report_mismatch("end_of_area", got.end_of_area, want.end_of_area);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int            i;
        int            k;
        int            n;
        int            n_regs;
        int            n_words;
        int            phases;
        int            directed_words;
        logic [31:0]   idx;
        logic [31:0]   first_idx;
        logic [31:0]   mask;
        logic [31:0]   reg_vals [NUM_REGS];
        logic [15:0]   word;
        pixel_t        first_px;
        directed_row_t r;

        phases = 0;
        blit_mode    = MODE_REPLACE;
        fg_color     = '0;
        bg_color     = '0;
        start_offset = '0;
        width_reg    = '0;
        height_reg   = '0;
        restart_blit();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            r = directed_rows[i];
            if (r.kind == ROW_WRITE_REG)
                write_register(r.index, r.data);
            else
            begin
                send_word(r.data[15:0], n);
                if (r.n_pixels != NOT_TYPED)
                begin
                    if (n != int'(r.n_pixels))
                        report_mismatch("directed pixel count", n, r.n_pixels);
                    else if (n > 0)
                    begin
                        first_px = expected_pixels[expected_pixels.size() - n];
                        if (first_px.action != r.first_action)
                            report_mismatch("directed first action", first_px.action,
                                            r.first_action);
                        if (first_px.value != r.first_value)
                            report_mismatch("directed first value", first_px.value,
                                            r.first_value);
                    end
                end
                pace_sender();
            end
        end
        directed_words = words_sent;

        while (words_sent < ITEMS)
        begin
            phases++;
            reg_vals[REG_DRAW_MODE] = $urandom_range(0, 3);
            case ($urandom_range(0, 5))
                0:       reg_vals[REG_FOREGROUND] = 32'h0;
                1:       reg_vals[REG_FOREGROUND] = 32'hffff_ffff;
                default: reg_vals[REG_FOREGROUND] = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       reg_vals[REG_BACKGROUND] = 32'h0;
                1:       reg_vals[REG_BACKGROUND] = 32'hffff_ffff;
                default: reg_vals[REG_BACKGROUND] = $urandom;
            endcase
            reg_vals[REG_START_BIT] = $urandom_range(0, 15);
            case ($urandom_range(0, 19))
                0:       reg_vals[REG_WIDTH] = 0;
                1:       reg_vals[REG_WIDTH] = 16 - reg_vals[REG_START_BIT];
                2:       reg_vals[REG_WIDTH] = 32 - reg_vals[REG_START_BIT];
                3:       reg_vals[REG_WIDTH] = MAX_W;
                4:       reg_vals[REG_WIDTH] = $urandom_range(MAX_W + 1, 8191);
                5:       reg_vals[REG_WIDTH] = 1;
                default: reg_vals[REG_WIDTH] = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 14))
                0:       reg_vals[REG_HEIGHT] = 0;
                1:       reg_vals[REG_HEIGHT] = $urandom_range(MAX_H + 1, 8191);
                2:       reg_vals[REG_HEIGHT] = MAX_H;
                default: reg_vals[REG_HEIGHT] = $urandom_range(1, 4);
            endcase

            // now and then only a few registers change
            n_regs    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : NUM_REGS;
            first_idx = $urandom_range(0, NUM_REGS - 1);
            for (k = 0; k < n_regs; k++)
            begin
                idx = (first_idx + k) % NUM_REGS;
                case (idx)
                    REG_DRAW_MODE:         mask = 32'h3;
                    REG_START_BIT:         mask = 32'hf;
                    REG_WIDTH, REG_HEIGHT: mask = 32'h1fff;
                    default:               mask = 32'hffff_ffff;
                endcase
                // stray bits above the field must be ignored
                if ($urandom_range(0, 3) == 0)
                    write_register(idx, reg_vals[idx] | ($urandom & ~mask));
                else
                    write_register(idx, reg_vals[idx]);
            end

            // one full area where it is small, sometimes one to three words past its end
            n_words = int'(clipped_height())
                      * ((int'(start_offset) + int'(clipped_width())) / 16 + 1);
            if (n_words > PHASE_WORDS)
                n_words = PHASE_WORDS;
            if ($urandom_range(0, 2) == 0)
                n_words += $urandom_range(1, 3);

            for (k = 0; k < n_words; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       word = 16'h0000;
                    1:       word = 16'hffff;
                    default: word = 16'($urandom_range(0, 65535));
                endcase
                send_word(word, n);
                pace_sender();
            end
        end

        s_tvalid <= 1'b0;
        for (k = 0; k < END_WAIT && expected_pixels.size() != 0; k++)
            @(posedge clk);
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixels never delivered", expected_pixels.size(), 0);

        $display("sent %0d source words (%0d directed) across %0d random register settings",
                 words_sent, directed_words, phases);
        $display("checked %0d pixel beats, %0d mismatches", beats_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
sv/mcx_pkg.sv
sv/mcx_cfg_regs.sv
sv/mcx_expand.sv
sv/mcx_out_reg.sv
sv/mono_color_expand_blit.sv
verif/tb_mono_color_expand_blit.sv
